/* src/bfa_pkg.sv */
// Shared types and constants of the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int WORD_W    = 32;  // map bits per memory word
  localparam int WORD_LOG2 = 5;
  localparam int ADDR_W    = 32;
  localparam int FREE_W    = 13;
  localparam int GRAN_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [GRAN_W-1:0] GRAN_RESET = 5'd12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAN  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_QUERY   = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    logic              ok;
    logic [FREE_W-1:0] free_frames;
  } rsp_t;

  typedef struct packed {
    logic                 found;
    logic [WORD_LOG2-1:0] bit_idx;
  } hit_t;

endpackage

/* src/bfa_scan.sv */
// Free-bit search over one map word, limited to the usable frame window.
`timescale 1ns / 1ps

module bfa_scan #(
  parameter int CW = 13
) (
  input  logic [bfa_pkg::WORD_W-1:0]                  word_i,
  input  logic [CW+bfa_pkg::WORD_LOG2:0]              base_i,
  input  logic [CW-1:0]                               total_i,
  input  logic [CW-1:0]                               hint_i,
  input  logic                                        first_i,
  output bfa_pkg::hit_t                               hit_o
);

  localparam int XW = CW + bfa_pkg::WORD_LOG2 + 1;

  logic [XW-1:0]                 idx_w [bfa_pkg::WORD_W];
  logic [bfa_pkg::WORD_W-1:0]    usable;

  always_comb begin
    for (int j = 0; j < bfa_pkg::WORD_W; j++) begin
      idx_w[j]  = base_i + XW'(j);
      usable[j] = !word_i[j] && (idx_w[j] < XW'(total_i)) &&
                  !(first_i && (idx_w[j] < XW'(hint_i)));
    end
  end

  // lowest usable free bit wins
  always_comb begin
    hit_o = '0;
    for (int j = bfa_pkg::WORD_W - 1; j >= 0; j--) begin
      if (usable[j]) begin
        hit_o.found   = 1'b1;
        hit_o.bit_idx = bfa_pkg::WORD_LOG2'(j);
      end
    end
  end

endmodule

/* src/bitmap_frame_allocator_core.sv */
// Top level: next-fit bitmap frame allocator with the map in one word-wide RAM.
`timescale 1ns / 1ps

//  channel   | signals                                  | transaction completes
//  ----------+------------------------------------------+------------------------------
//  request   | start, busy, req_i (func, addr)          | edge with start high, busy low
//  result    | rsp_valid_o, rsp_o (frame_addr, ok, free)| edge ending the one-cycle strobe
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i          | edge with cfg_we_i high
//
// Allocate reads the map one RAM word per cycle, starting at the hint's word and reading
// up to ceil(MAX_FRAMES/32) + 1 words when the search wraps back into the hint's word.
// Release and query read a single map word; rejected requests answer without a read.
// The single RAM read port is registered.
// After reset and after each configuration write the block runs a clearing pass with
// busy high, rewriting every map word.
// The receiver cannot stall: the strobe lasts one cycle and a new request may be
// accepted in that same cycle.

module bitmap_frame_allocator_core #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  bfa_pkg::req_t                     req_i,
  output logic                              rsp_valid_o,
  output bfa_pkg::rsp_t                     rsp_o,
  input  logic                              cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bfa_pkg::ADDR_W-1:0]        cfg_data_i
);

  localparam int CW    = $clog2(MAX_FRAMES + 1);
  localparam int XW    = CW + bfa_pkg::WORD_LOG2 + 1;
  localparam int WORDS = (MAX_FRAMES + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  // controller states
  localparam logic [2:0] ST_SETUP = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_DISP  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_TAKE  = 3'd6;

  // configuration registers
  logic [bfa_pkg::ADDR_W-1:0] base_q;
  logic [bfa_pkg::ADDR_W-1:0] bytes_q;
  logic [bfa_pkg::GRAN_W-1:0] gran_q;
  logic                       cfg_hit;

  // allocator state
  logic [2:0]          state_q, state_d;
  logic                init_q, init_d;
  logic [CW-1:0]       total_q, total_d;
  logic [CW-1:0]       resv_q, resv_d;
  logic [CW-1:0]       free_q, free_d;
  logic [CW-1:0]       hint_q, hint_d;
  logic [WAW-1:0]      clr_q, clr_d;
  logic [XW-1:0]       scan_q, scan_d;
  logic                first_q, first_d;
  logic [XW-1:0]       idx_q, idx_d;
  bfa_pkg::req_t       req_q, req_d;
  bfa_pkg::rsp_t       rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;

  // map RAM
  logic [bfa_pkg::WORD_W-1:0] map_mem [WORDS];
  logic [bfa_pkg::WORD_W-1:0] rd_q;
  logic                       mem_we;
  logic [WAW-1:0]             mem_wa;
  logic [bfa_pkg::WORD_W-1:0] mem_wd;
  logic [WAW-1:0]             mem_ra;

  // region geometry
  logic [bfa_pkg::ADDR_W-1:0] gmask;
  logic [bfa_pkg::ADDR_W-1:0] frames32;
  logic [CW-1:0]              frames_sat;
  logic [bfa_pkg::ADDR_W-1:0] map_bytes;
  logic [bfa_pkg::ADDR_W-1:0] resv32;
  logic                       geo_valid;

  // address decode
  logic [bfa_pkg::ADDR_W-1:0] off_w;
  logic [bfa_pkg::ADDR_W-1:0] fidx32;
  logic                       loc_ok;
  logic [XW-1:0]              loc_idx;

  // clearing pass word and scan helpers
  logic [XW-1:0]              clr_base;
  logic [bfa_pkg::WORD_W-1:0] clr_word;
  logic [XW-1:0]              scan_start;
  logic [XW-1:0]              scan_next;
  logic [XW-1:0]              hit_idx;
  logic [bfa_pkg::WORD_W-1:0] bit_sel;
  bfa_pkg::hit_t              hit;

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == bfa_pkg::CFG_BASE) ||
                                (cfg_idx_i == bfa_pkg::CFG_BYTES) ||
                                (cfg_idx_i == bfa_pkg::CFG_GRAN));

  // Config registers: ignore writes to unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= '0;
      gran_q  <= bfa_pkg::GRAN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfa_pkg::CFG_BASE:  base_q  <= cfg_data_i;
        bfa_pkg::CFG_BYTES: bytes_q <= cfg_data_i;
        bfa_pkg::CFG_GRAN:  gran_q  <= cfg_data_i[bfa_pkg::GRAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame count, map size in frames and validity of the setting.
  always_comb begin
    gmask      = ~({bfa_pkg::ADDR_W{1'b1}} << gran_q);
    frames32   = bytes_q >> gran_q;
    frames_sat = (frames32 > bfa_pkg::ADDR_W'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                          : CW'(frames32);
    map_bytes  = (bfa_pkg::ADDR_W'(frames_sat) + bfa_pkg::ADDR_W'(7)) >> 3;
    resv32     = (map_bytes >> gran_q) +
                 bfa_pkg::ADDR_W'(|(map_bytes & gmask));
    geo_valid  = (base_q != '0) && ((base_q & gmask) == '0) &&
                 (frames_sat != '0) && (resv32 < bfa_pkg::ADDR_W'(frames_sat));
  end

  // Address to frame index for release and query.
  always_comb begin
    off_w   = req_q.addr - base_q;
    fidx32  = off_w >> gran_q;
    loc_ok  = init_q && (req_q.addr >= base_q) && ((off_w & gmask) == '0) &&
              (fidx32 < bfa_pkg::ADDR_W'(total_q));
    loc_idx = XW'(fidx32);
  end

  // Reset image of one map word: reserved frames set.
  always_comb begin
    clr_base = XW'(clr_q) << bfa_pkg::WORD_LOG2;
    for (int j = 0; j < bfa_pkg::WORD_W; j++) begin
      clr_word[j] = (clr_base + XW'(j)) < XW'(resv_q);
    end
  end

  // Next-fit start: word of the hint, or the first word once the hint ran off the end.
  assign scan_start = (hint_q >= total_q) ? '0
                    : (XW'(hint_q) & ~XW'(bfa_pkg::WORD_W - 1));
  assign scan_next  = scan_q + XW'(bfa_pkg::WORD_W);

  bfa_scan #(
    .CW (CW)
  ) u_scan (
    .word_i  (rd_q),
    .base_i  (scan_q),
    .total_i (total_q),
    .hint_i  (hint_q),
    .first_i (first_q),
    .hit_o   (hit)
  );

  assign hit_idx = scan_q + XW'(hit.bit_idx);
  assign bit_sel = bfa_pkg::WORD_W'(1) << idx_q[bfa_pkg::WORD_LOG2-1:0];

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    total_d     = total_q;
    resv_d      = resv_q;
    free_d      = free_q;
    hint_d      = hint_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    first_d     = first_q;
    idx_d       = idx_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_ra      = '0;

    case (state_q)
      ST_SETUP: begin
        // latch the geometry of the new setting, then clear the map
        init_d  = geo_valid;
        total_d = geo_valid ? frames_sat : '0;
        resv_d  = geo_valid ? CW'(resv32) : '0;
        free_d  = geo_valid ? (frames_sat - CW'(resv32)) : '0;
        hint_d  = geo_valid ? CW'(resv32) : '0;
        clr_d   = '0;
        state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = clr_word;
        clr_d  = clr_q + WAW'(1);
        if (clr_q == WAW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        rsp_d.frame_addr  = '0;
        rsp_d.ok          = 1'b0;
        rsp_d.free_frames = bfa_pkg::FREE_W'(free_q);
        case (req_q.func)
          bfa_pkg::FUNC_ALLOC: begin
            if (init_q && (free_q != '0)) begin
              scan_d  = scan_start;
              first_d = (hint_q < total_q);
              mem_ra  = scan_start[WAW+bfa_pkg::WORD_LOG2-1:bfa_pkg::WORD_LOG2];
              state_d = ST_SCAN;
            end else begin
              rsp_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          bfa_pkg::FUNC_RELEASE, bfa_pkg::FUNC_QUERY: begin
            if (loc_ok && ((req_q.func == bfa_pkg::FUNC_QUERY) ||
                           (loc_idx >= XW'(resv_q)))) begin
              idx_d   = loc_idx;
              mem_ra  = loc_idx[WAW+bfa_pkg::WORD_LOG2-1:bfa_pkg::WORD_LOG2];
              state_d = ST_CHECK;
            end else begin
              rsp_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          default: begin
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (hit.found) begin
          // claim the bit and advance the hint past it
          mem_we  = 1'b1;
          mem_wa  = scan_q[WAW+bfa_pkg::WORD_LOG2-1:bfa_pkg::WORD_LOG2];
          mem_wd  = rd_q | (bfa_pkg::WORD_W'(1) << hit.bit_idx);
          free_d  = free_q - CW'(1);
          hint_d  = CW'(hit_idx + XW'(1));
          idx_d   = hit_idx;
          state_d = ST_TAKE;
        end else begin
          // go on to the next word, wrapping to the first word past the last frame
          scan_d  = (scan_next >= XW'(total_q)) ? '0 : scan_next;
          first_d = 1'b0;
          mem_ra  = scan_d[WAW+bfa_pkg::WORD_LOG2-1:bfa_pkg::WORD_LOG2];
        end
      end
      ST_TAKE: begin
        rsp_d.frame_addr  = base_q + (bfa_pkg::ADDR_W'(idx_q) << gran_q);
        rsp_d.ok          = 1'b1;
        rsp_d.free_frames = bfa_pkg::FREE_W'(free_q);
        rsp_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_CHECK: begin
        rsp_d.frame_addr = '0;
        rsp_d.ok         = |(rd_q & bit_sel);
        if ((req_q.func == bfa_pkg::FUNC_RELEASE) && (|(rd_q & bit_sel))) begin
          // drop the bit, count it free and pull the hint down
          mem_we = 1'b1;
          mem_wa = idx_q[WAW+bfa_pkg::WORD_LOG2-1:bfa_pkg::WORD_LOG2];
          mem_wd = rd_q & ~bit_sel;
          free_d = free_q + CW'(1);
          if (idx_q < XW'(hint_q)) begin
            hint_d = CW'(idx_q);
          end
        end
        rsp_d.free_frames = bfa_pkg::FREE_W'(free_d);
        rsp_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_SETUP;
      end
    endcase

    // every accepted register write re-initializes the map
    if (cfg_hit) begin
      state_d = ST_SETUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SETUP;
      init_q      <= 1'b0;
      total_q     <= '0;
      resv_q      <= '0;
      free_q      <= '0;
      hint_q      <= '0;
      clr_q       <= '0;
      first_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      total_q     <= total_d;
      resv_q      <= resv_d;
      free_q      <= free_d;
      hint_q      <= hint_d;
      clr_q       <= clr_d;
      first_q     <= first_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    idx_q  <= idx_d;
    req_q  <= req_d;
    rsp_q  <= rsp_d;
  end

  // map RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_q <= map_mem[mem_ra];
  end

endmodule
